/* design/rau_pkg.sv */
// rational accumulator unit: shared package
// operation kind codes, shared unit command codes and command struct; no dependencies
`default_nettype none

package rau_pkg;

    // operation kinds carried on the input channel
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RED   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NEG   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RECIP = 3'd7;

    // operand field width
    localparam int OPND_W = 32;

    // shared arithmetic unit modes
    typedef logic [1:0] t_alu_mode;
    localparam t_alu_mode ALU_MUL = 2'd0;
    localparam t_alu_mode ALU_DIV = 2'd1;
    localparam t_alu_mode ALU_GCD = 2'd2;

    typedef struct packed {
        logic      start;
        t_alu_mode mode;
    } t_alu_cmd;

endpackage

`default_nettype wire

/* design/rau_alu.sv */
// rational accumulator unit: iterative shared arithmetic unit
// shift-add multiply, restoring divide and binary gcd; depends on rau_pkg
`default_nettype none

module rau_alu #(
    parameter int W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rau_pkg::t_alu_cmd i_cmd,
    input  wire logic [W-1:0]      i_a,
    input  wire logic [W-1:0]      i_b,
    output logic                   o_done,
    output logic [2*W-1:0]         o_prod,
    output logic [W-1:0]           o_quot,
    output logic [W-1:0]           o_gcd
);
    import rau_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic            r_fix, n_fix;
    t_alu_mode       r_mode, n_mode;
    logic [W-1:0]    r_x, n_x;
    logic [W-1:0]    r_hi, n_hi;
    logic [W-1:0]    r_lo, n_lo;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_k, n_k;

    logic [W:0]      add_sum;
    logic [W:0]      trial;
    logic [W:0]      diff;

    // one step of the selected operation per cycle while busy
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_fix   = r_fix;
        n_mode  = r_mode;
        n_x     = r_x;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_cnt   = r_cnt;
        n_k     = r_k;
        add_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_x} : '0);
        trial   = {r_hi, r_lo[W-1]} - {1'b0, r_x};
        diff    = {1'b0, r_hi} - {1'b0, r_lo};
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_mode = i_cmd.mode;
            n_fix  = 1'b0;
            n_k    = '0;
            n_cnt  = CW'(W);
            case (i_cmd.mode)
                ALU_MUL: begin
                    n_x  = i_a;
                    n_lo = i_b;
                    n_hi = '0;
                end
                ALU_DIV: begin
                    n_x  = i_b;
                    n_lo = i_a;
                    n_hi = '0;
                end
                default: begin
                    n_hi = i_a;
                    n_lo = i_b;
                end
            endcase
        end else if (r_busy) begin
            case (r_mode)
                ALU_MUL: begin
                    n_hi  = add_sum[W:1];
                    n_lo  = {add_sum[0], r_lo[W-1:1]};
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                ALU_DIV: begin
                    n_hi  = trial[W] ? {r_hi[W-2:0], r_lo[W-1]} : trial[W-1:0];
                    n_lo  = {r_lo[W-2:0], ~trial[W]};
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
                default: begin
                    if (r_fix) begin
                        // restore the common power of two
                        if (r_k == '0) begin
                            n_busy = 1'b0;
                            n_done = 1'b1;
                        end else begin
                            n_hi = {r_hi[W-2:0], 1'b0};
                            n_k  = r_k - 1'b1;
                        end
                    end else if (r_hi == '0) begin
                        n_hi  = r_lo;
                        n_fix = 1'b1;
                    end else if (r_lo == '0) begin
                        n_fix = 1'b1;
                    end else if (!r_hi[0] && !r_lo[0]) begin
                        n_hi = {1'b0, r_hi[W-1:1]};
                        n_lo = {1'b0, r_lo[W-1:1]};
                        n_k  = r_k + 1'b1;
                    end else if (!r_hi[0]) begin
                        n_hi = {1'b0, r_hi[W-1:1]};
                    end else if (!r_lo[0]) begin
                        n_lo = {1'b0, r_lo[W-1:1]};
                    end else if (!diff[W]) begin
                        n_hi = diff[W-1:0];
                    end else begin
                        n_lo = '0 - diff[W-1:0];
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_fix  <= n_fix;
        r_mode <= n_mode;
        r_x    <= n_x;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
    assign o_quot = r_lo;
    assign o_gcd  = r_hi;

endmodule

`default_nettype wire

/* design/rational_accumulator_unit.sv */
// rational accumulator unit: top level with operation sequencer
// depends on rau_pkg and rau_alu
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_kind, i_operand_numerator/_denominator
//  out     | output    | o_out_valid / i_out_stall| o_result_*, o_overflowed, o_zero_denominator
//
// one transaction at a time; o_in_stall is high from acceptance until the result is registered.
// load, negate, reciprocal: done in the sequencer alone; multiply, divide: two multiplies on the
// shared unit (W = max(MAG_BITS,32) bits wide). add, subtract: gcd, then two divides and three
// multiplies on the one shared unit; reduce: gcd then two divides, which a zero gcd skips.
// reset (synchronous, active low) sets the accumulator to +0/1 and empties the output register.
// a new transaction is taken while a finished result still waits under i_out_stall.
`default_nettype none

module rational_accumulator_unit #(
    parameter int MAG_BITS = 31
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [2:0]          i_kind,
    input  wire logic signed [31:0]  i_operand_numerator,
    input  wire logic signed [31:0]  i_operand_denominator,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_result_negative,
    output logic [MAG_BITS-1:0]      o_result_numerator,
    output logic [MAG_BITS-1:0]      o_result_denominator,
    output logic                     o_overflowed,
    output logic                     o_zero_denominator
);
    import rau_pkg::*;

    localparam int W  = (MAG_BITS > OPND_W) ? MAG_BITS : OPND_W;
    localparam int PW = 2 * W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_AGCD  = 4'd2;
    localparam logic [3:0] S_AFOP  = 4'd3;
    localparam logic [3:0] S_AFACC = 4'd4;
    localparam logic [3:0] S_AX    = 4'd5;
    localparam logic [3:0] S_AY    = 4'd6;
    localparam logic [3:0] S_ADEN  = 4'd7;
    localparam logic [3:0] S_ASUM  = 4'd8;
    localparam logic [3:0] S_RGCD  = 4'd9;
    localparam logic [3:0] S_RNUM  = 4'd10;
    localparam logic [3:0] S_RDEN  = 4'd11;
    localparam logic [3:0] S_MNUM  = 4'd12;
    localparam logic [3:0] S_MDEN  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]           r_state, n_state;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic                 r_op_neg, n_op_neg;
    logic [OPND_W-1:0]    r_op_num, n_op_num;
    logic [OPND_W-1:0]    r_op_den, n_op_den;
    logic                 r_acc_neg, n_acc_neg;
    logic [MAG_BITS-1:0]  r_acc_num, n_acc_num;
    logic [MAG_BITS-1:0]  r_acc_den, n_acc_den;
    logic                 r_ovf, n_ovf;
    logic [W-1:0]         r_g, n_g;
    logic [W-1:0]         r_fop, n_fop;
    logic [W-1:0]         r_facc, n_facc;
    logic [PW-1:0]        r_x, n_x;
    logic [PW-1:0]        r_y, n_y;
    logic                 r_out_valid, n_out_valid;
    logic                 r_res_neg;
    logic [MAG_BITS-1:0]  r_res_num;
    logic [MAG_BITS-1:0]  r_res_den;
    logic                 r_res_ovf;

    t_alu_cmd             alu_cmd;
    logic [W-1:0]         alu_a, alu_b;
    logic                 alu_done;
    logic [PW-1:0]        alu_prod;
    logic [W-1:0]         alu_quot, alu_gcd;

    logic                 in_accept;
    logic                 out_free;
    logic                 nneg, dneg;
    logic [OPND_W-1:0]    nmag, dmag;
    logic [W-1:0]         load_num, load_den;
    logic [W-1:0]         g_fixed;
    logic                 prod_ovf;
    logic [PW:0]          sum;
    logic                 sum_neg;
    logic                 x_ge_y;

    rau_alu #(
        .W(W)
    ) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (alu_cmd),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_done (alu_done),
        .o_prod (alu_prod),
        .o_quot (alu_quot),
        .o_gcd  (alu_gcd)
    );

    // operand sign and magnitudes
    assign nneg = i_operand_numerator[OPND_W-1];
    assign dneg = i_operand_denominator[OPND_W-1];
    assign nmag = nneg ? ('0 - i_operand_numerator) : i_operand_numerator;
    assign dmag = dneg ? ('0 - i_operand_denominator) : i_operand_denominator;

    assign in_accept = (r_state == S_IDLE) && i_in_valid;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign load_num  = W'(r_op_num);
    assign load_den  = W'(r_op_den);
    assign g_fixed   = (alu_gcd == '0) ? W'(1) : alu_gcd;
    assign prod_ovf  = (alu_prod >> MAG_BITS) != '0;
    assign x_ge_y    = r_x >= r_y;

    // signed-magnitude sum of the two scaled numerators
    always_comb begin
        if (r_acc_neg == r_op_neg) begin
            sum     = {1'b0, r_x} + {1'b0, r_y};
            sum_neg = r_acc_neg;
        end else if (x_ge_y) begin
            sum     = {1'b0, r_x} - {1'b0, r_y};
            sum_neg = r_acc_neg;
        end else begin
            sum     = {1'b0, r_y} - {1'b0, r_x};
            sum_neg = r_op_neg;
        end
        if (sum == '0) begin
            sum_neg = 1'b0;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_op_neg    = r_op_neg;
        n_op_num    = r_op_num;
        n_op_den    = r_op_den;
        n_acc_neg   = r_acc_neg;
        n_acc_num   = r_acc_num;
        n_acc_den   = r_acc_den;
        n_ovf       = r_ovf;
        n_g         = r_g;
        n_fop       = r_fop;
        n_facc      = r_facc;
        n_x         = r_x;
        n_y         = r_y;
        n_out_valid = r_out_valid && i_out_stall;
        alu_cmd     = '{start: 1'b0, mode: ALU_MUL};
        alu_a       = '0;
        alu_b       = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_kind   = i_kind;
                    n_op_num = nmag;
                    n_op_den = dmag;
                    n_op_neg = ((nneg && !dneg && dmag != '0) ||
                                (!nneg && nmag != '0 && dneg)) ^ (i_kind == KIND_SUB);
                    n_ovf    = 1'b0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_kind)
                    KIND_LOAD: begin
                        n_acc_neg = r_op_neg;
                        n_acc_num = load_num[MAG_BITS-1:0];
                        n_acc_den = load_den[MAG_BITS-1:0];
                        n_ovf     = ((load_num >> MAG_BITS) != '0) ||
                                    ((load_den >> MAG_BITS) != '0);
                        n_state   = S_OUT;
                    end
                    KIND_ADD, KIND_SUB: begin
                        alu_cmd = '{start: 1'b1, mode: ALU_GCD};
                        alu_a   = W'(r_acc_den);
                        alu_b   = load_den;
                        n_state = S_AGCD;
                    end
                    KIND_MUL, KIND_DIV: begin
                        alu_cmd = '{start: 1'b1, mode: ALU_MUL};
                        alu_a   = W'(r_acc_num);
                        alu_b   = (r_kind == KIND_MUL) ? load_num : load_den;
                        n_state = S_MNUM;
                    end
                    KIND_RED: begin
                        alu_cmd = '{start: 1'b1, mode: ALU_GCD};
                        alu_a   = W'(r_acc_num);
                        alu_b   = W'(r_acc_den);
                        n_state = S_RGCD;
                    end
                    KIND_NEG: begin
                        n_acc_neg = !r_acc_neg;
                        n_state   = S_OUT;
                    end
                    default: begin
                        n_acc_num = r_acc_den;
                        n_acc_den = r_acc_num;
                        n_state   = S_OUT;
                    end
                endcase
            end
            // add: common denominator factors
            S_AGCD: begin
                if (alu_done) begin
                    n_g     = g_fixed;
                    alu_cmd = '{start: 1'b1, mode: ALU_DIV};
                    alu_a   = W'(r_acc_den);
                    alu_b   = g_fixed;
                    n_state = S_AFOP;
                end
            end
            S_AFOP: begin
                if (alu_done) begin
                    n_fop   = alu_quot;
                    alu_cmd = '{start: 1'b1, mode: ALU_DIV};
                    alu_a   = load_den;
                    alu_b   = r_g;
                    n_state = S_AFACC;
                end
            end
            S_AFACC: begin
                if (alu_done) begin
                    n_facc  = alu_quot;
                    alu_cmd = '{start: 1'b1, mode: ALU_MUL};
                    alu_a   = W'(r_acc_num);
                    alu_b   = alu_quot;
                    n_state = S_AX;
                end
            end
            S_AX: begin
                if (alu_done) begin
                    n_x     = alu_prod;
                    alu_cmd = '{start: 1'b1, mode: ALU_MUL};
                    alu_a   = load_num;
                    alu_b   = r_fop;
                    n_state = S_AY;
                end
            end
            S_AY: begin
                if (alu_done) begin
                    n_y     = alu_prod;
                    alu_cmd = '{start: 1'b1, mode: ALU_MUL};
                    alu_a   = W'(r_acc_den);
                    alu_b   = r_facc;
                    n_state = S_ADEN;
                end
            end
            S_ADEN: begin
                if (alu_done) begin
                    n_acc_den = alu_prod[MAG_BITS-1:0];
                    n_ovf     = r_ovf || prod_ovf;
                    n_state   = S_ASUM;
                end
            end
            S_ASUM: begin
                n_acc_neg = sum_neg;
                n_acc_num = sum[MAG_BITS-1:0];
                n_ovf     = r_ovf || ((sum >> MAG_BITS) != '0);
                n_state   = S_OUT;
            end
            // reduce by the gcd, 0/0 left alone
            S_RGCD: begin
                if (alu_done) begin
                    if (alu_gcd == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_g     = alu_gcd;
                        alu_cmd = '{start: 1'b1, mode: ALU_DIV};
                        alu_a   = W'(r_acc_num);
                        alu_b   = alu_gcd;
                        n_state = S_RNUM;
                    end
                end
            end
            S_RNUM: begin
                if (alu_done) begin
                    n_acc_num = alu_quot[MAG_BITS-1:0];
                    alu_cmd   = '{start: 1'b1, mode: ALU_DIV};
                    alu_a     = W'(r_acc_den);
                    alu_b     = r_g;
                    n_state   = S_RDEN;
                end
            end
            S_RDEN: begin
                if (alu_done) begin
                    n_acc_den = alu_quot[MAG_BITS-1:0];
                    n_state   = S_OUT;
                end
            end
            // multiply and divide
            S_MNUM: begin
                if (alu_done) begin
                    n_acc_num = alu_prod[MAG_BITS-1:0];
                    n_ovf     = r_ovf || prod_ovf;
                    alu_cmd   = '{start: 1'b1, mode: ALU_MUL};
                    alu_a     = W'(r_acc_den);
                    alu_b     = (r_kind == KIND_MUL) ? load_den : load_num;
                    n_state   = S_MDEN;
                end
            end
            S_MDEN: begin
                if (alu_done) begin
                    n_acc_den = alu_prod[MAG_BITS-1:0];
                    n_ovf     = r_ovf || prod_ovf;
                    n_acc_neg = r_acc_neg ^ r_op_neg;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc_neg   <= 1'b0;
            r_acc_num   <= '0;
            r_acc_den   <= MAG_BITS'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc_neg   <= n_acc_neg;
            r_acc_num   <= n_acc_num;
            r_acc_den   <= n_acc_den;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_op_neg <= n_op_neg;
        r_op_num <= n_op_num;
        r_op_den <= n_op_den;
        r_ovf    <= n_ovf;
        r_g      <= n_g;
        r_fop    <= n_fop;
        r_facc   <= n_facc;
        r_x      <= n_x;
        r_y      <= n_y;
    end

    // output register, loaded when the result is handed over
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_res_neg <= r_acc_neg;
            r_res_num <= r_acc_num;
            r_res_den <= r_acc_den;
            r_res_ovf <= r_ovf;
        end
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_result_negative    = r_res_neg;
    assign o_result_numerator   = r_res_num;
    assign o_result_denominator = r_res_den;
    assign o_overflowed         = r_res_ovf;
    assign o_zero_denominator   = (r_res_den == '0);

endmodule

`default_nettype wire
